/* rtl/assert_macros.svh */
// Assertion macros for the boundary depth mean/deviation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define BDMD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdmd assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define BDMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdmd assertion failed");

`endif

/* rtl/bdmd_pkg.sv */
// Package: constants, widths and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none

package bdmd_pkg;

  localparam int MAX_PAIRS  = 4096;
  localparam int DEPTH_BITS = 16;

  localparam int ADDR_W    = $clog2(MAX_PAIRS);
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W     = DEPTH_BITS + ADDR_W;
  localparam int FRAC_W    = 8;
  localparam int DVD_W     = SUM_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);
  localparam int RES_W     = 24;

  localparam int IN_W  = 16;
  localparam int CNT_OUT_W = 13;

  typedef struct packed {
    logic acc_item;
    logic div_start;
    logic div_sel_mad;
    logic take_mean;
    logic pass_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_busy;
    logic pass_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/bdmd_div.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bdmd_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bdmd_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [bdmd_pkg::CNT_W-1:0]    divisor_i,
  output logic                               busy_o,
  output logic [bdmd_pkg::DVD_W-1:0]         quot_o
);
  import bdmd_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dsr_q, dsr_d;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? CNT_W'(rem_sh - {1'b0, dsr_q}) : CNT_W'(rem_sh);
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* rtl/bdmd_ctrl.sv */
// Controller: sequences accept, mean divide, deviation pass, deviation divide, output
`timescale 1ns / 1ps
`default_nettype none

module bdmd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           last_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire bdmd_pkg::sts_t sts_i,
  output bdmd_pkg::cmd_t      cmd_o
);
  import bdmd_pkg::*;

  localparam logic [2:0] S_ACCEPT    = 3'd0;
  localparam logic [2:0] S_CHECK     = 3'd1;
  localparam logic [2:0] S_MEAN_DIV  = 3'd2;
  localparam logic [2:0] S_PASS      = 3'd3;
  localparam logic [2:0] S_TAIL      = 3'd4;
  localparam logic [2:0] S_MAD_START = 3'd5;
  localparam logic [2:0] S_MAD_DIV   = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       xfer_in;

  assign in_ready_o = (state_q == S_ACCEPT);
  assign xfer_in    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_ACCEPT: begin
        cmd_o.acc_item = xfer_in;
        if (xfer_in && last_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.cnt_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_MEAN_DIV;
        end
      end
      S_MEAN_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_mean = 1'b1;
          state_d         = S_PASS;
        end
      end
      S_PASS: begin
        cmd_o.pass_rd = 1'b1;
        if (sts_i.pass_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_MAD_START;
      end
      S_MAD_START: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_mad = 1'b1;
        state_d           = S_MAD_DIV;
      end
      S_MAD_DIV: begin
        cmd_o.div_sel_mad = 1'b1;
        if (!sts_i.div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_ACCEPT;
        end
      end
      default: begin
        state_d = S_ACCEPT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCEPT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/bdmd_dpath.sv */
// Datapath: difference store, sum and count, deviation accumulator, divider, output registers
`timescale 1ns / 1ps
`default_nettype none

module bdmd_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bdmd_pkg::cmd_t                    cmd_i,
  output bdmd_pkg::sts_t                         sts_o,
  input  wire logic [bdmd_pkg::IN_W-1:0]         near_depth_i,
  input  wire logic [bdmd_pkg::IN_W-1:0]         far_depth_i,
  input  wire logic                              invalid_i,
  output logic [bdmd_pkg::RES_W-1:0]             mean_depth_o,
  output logic [bdmd_pkg::RES_W-1:0]             mean_abs_dev_o,
  output logic [bdmd_pkg::CNT_OUT_W-1:0]         valid_count_o,
  output logic                                   no_valid_o,
  output logic                                   overflow_o
);
  import bdmd_pkg::*;

  logic [DEPTH_BITS-1:0] mem [MAX_PAIRS];

  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic [RES_W-1:0]      mean_q;
  logic [ADDR_W-1:0]     idx_q;
  logic                  rd_vld_q;
  logic [DEPTH_BITS-1:0] rdata_q;
  logic [DVD_W-1:0]      acc_q;

  logic [DEPTH_BITS-1:0] a, b, d;
  logic                  full, store_it;
  logic [RES_W-1:0]      v, term;
  logic                  div_busy;
  logic [DVD_W-1:0]      quot, dividend;

  logic [RES_W-1:0]      mean_out_q, mad_out_q;
  logic [CNT_OUT_W-1:0]  cnt_out_q;
  logic                  nv_out_q, ovf_out_q;

  assign a        = DEPTH_BITS'(near_depth_i);
  assign b        = DEPTH_BITS'(far_depth_i);
  assign d        = (a >= b) ? (a - b) : (b - a);
  assign full     = (cnt_q == CNT_W'(MAX_PAIRS));
  assign store_it = cmd_i.acc_item && !invalid_i && !full;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (store_it) begin
      sum_d = sum_q + SUM_W'(d);
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.acc_item && !invalid_i && full) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.load_out) begin
      sum_d = '0;
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      rd_vld_q <= cmd_i.pass_rd;
    end
  end

  // difference store, registered read
  always_ff @(posedge clk_i) begin
    if (store_it) begin
      mem[cnt_q[ADDR_W-1:0]] <= d;
    end
    rdata_q <= mem[idx_q];
  end

  // deviation pass
  assign v    = {rdata_q, FRAC_W'(0)};
  assign term = (v >= mean_q) ? (v - mean_q) : (mean_q - v);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_mean) begin
      mean_q <= quot[RES_W-1:0];
      idx_q  <= '0;
      acc_q  <= '0;
    end else begin
      if (cmd_i.pass_rd) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + DVD_W'(term);
      end
    end
  end

  assign dividend = cmd_i.div_sel_mad ? acc_q : {sum_q, FRAC_W'(0)};

  bdmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.pass_last = ({1'b0, idx_q} + CNT_W'(1)) == cnt_q;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_out_q <= (cnt_q == '0) ? '0 : mean_q;
      mad_out_q  <= (cnt_q == '0) ? '0 : quot[RES_W-1:0];
      cnt_out_q  <= CNT_OUT_W'(cnt_q);
      nv_out_q   <= (cnt_q == '0);
      ovf_out_q  <= ovf_q;
    end
  end

  assign mean_depth_o   = mean_out_q;
  assign mean_abs_dev_o = mad_out_q;
  assign valid_count_o  = cnt_out_q;
  assign no_valid_o     = nv_out_q;
  assign overflow_o     = ovf_out_q;

endmodule

`default_nettype wire

/* rtl/boundary_depth_mean_deviation_unit.sv */
// Top level: mean and mean absolute deviation of boundary depth differences
//
// Input channel (in_valid_i/in_ready_o) takes one depth pair per transfer,
// one transfer per cycle while a set streams in. Invalid pairs are skipped;
// valid pairs beyond 4096 are dropped and flag overflow.
// On the transfer marked last, in_ready_o drops while the block computes:
//   a check, the mean divide (one quotient bit per cycle), a deviation
//   pass over the stored differences (one memory read per cycle), a
//   setup state, the deviation divide and the output load; when no pair
//   was valid, the check goes straight to the output load. The shared
//   divider and the single read port of the difference store set how
//   long this takes.
// Output channel (out_valid_o/out_ready_i) holds one result register. A new
// set streams in while a result waits; a receiver stall only holds the next
// result load until the register is free.
// Reset clears sums, counts, flags and the output valid; the difference
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module boundary_depth_mean_deviation_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [bdmd_pkg::IN_W-1:0]         near_depth_i,
  input  wire logic [bdmd_pkg::IN_W-1:0]         far_depth_i,
  input  wire logic                              invalid_i,
  input  wire logic                              last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [bdmd_pkg::RES_W-1:0]             mean_depth_o,
  output logic [bdmd_pkg::RES_W-1:0]             mean_abs_dev_o,
  output logic [bdmd_pkg::CNT_OUT_W-1:0]         valid_count_o,
  output logic                                   no_valid_o,
  output logic                                   overflow_o
);
  import bdmd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic res_zero;

  bdmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bdmd_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .near_depth_i   (near_depth_i),
    .far_depth_i    (far_depth_i),
    .invalid_i      (invalid_i),
    .mean_depth_o   (mean_depth_o),
    .mean_abs_dev_o (mean_abs_dev_o),
    .valid_count_o  (valid_count_o),
    .no_valid_o     (no_valid_o),
    .overflow_o     (overflow_o)
  );

  assign res_zero = (mean_depth_o == '0) && (mean_abs_dev_o == '0) && (valid_count_o == '0);

  `BDMD_ASSERT(a_no_valid_zero, out_valid_o && no_valid_o, res_zero)
  `BDMD_ASSERT(a_count_range, out_valid_o, valid_count_o <= CNT_OUT_W'(MAX_PAIRS))
  `BDMD_ASSERT_NXT(a_last_blocks, in_valid_i && in_ready_o && last_i, !in_ready_o)
  `BDMD_ASSERT(a_idle_divider, in_ready_o, !sts.div_busy)

endmodule

`default_nettype wire

/* test/depth_stats_checker.sv */
// Checker: predicts per-set depth difference statistics and compares each result transfer
`timescale 1ns / 1ps
`default_nettype none

module depth_stats_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_i,
  input  wire logic [bdmd_pkg::IN_W-1:0]         near_depth_i,
  input  wire logic [bdmd_pkg::IN_W-1:0]         far_depth_i,
  input  wire logic                              invalid_i,
  input  wire logic                              last_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_ready_i,
  input  wire logic [bdmd_pkg::RES_W-1:0]        mean_depth_i,
  input  wire logic [bdmd_pkg::RES_W-1:0]        mean_abs_dev_i,
  input  wire logic [bdmd_pkg::CNT_OUT_W-1:0]    valid_count_i,
  input  wire logic                              no_valid_i,
  input  wire logic                              overflow_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  typedef struct packed {
    logic [bdmd_pkg::RES_W-1:0]     mean_depth;
    logic [bdmd_pkg::RES_W-1:0]     mean_abs_dev;
    logic [bdmd_pkg::CNT_OUT_W-1:0] valid_count;
    logic                           no_valid;
    logic                           overflow;
  } set_stats_t;

  logic [bdmd_pkg::DEPTH_BITS-1:0] diff_mem [bdmd_pkg::MAX_PAIRS];
  longint unsigned                 diff_total;
  int unsigned                     pair_cnt;
  logic                            dropped_seen;
  set_stats_t                      expected_stats_q [$];

  function automatic set_stats_t predict_set_stats();
    set_stats_t      s;
    longint unsigned mean_q8;
    longint unsigned dev_total;
    longint unsigned scaled;
    mean_q8   = 0;
    dev_total = 0;
    if (pair_cnt > 0) begin
      mean_q8 = (diff_total << 8) / pair_cnt;
      for (int i = 0; i < pair_cnt; i++) begin
        scaled = longint'(diff_mem[i]) << 8;
        dev_total += (scaled >= mean_q8) ? (scaled - mean_q8) : (mean_q8 - scaled);
      end
      dev_total = dev_total / pair_cnt;
    end
    s.mean_depth   = mean_q8[bdmd_pkg::RES_W-1:0];
    s.mean_abs_dev = dev_total[bdmd_pkg::RES_W-1:0];
    s.valid_count  = pair_cnt[bdmd_pkg::CNT_OUT_W-1:0];
    s.no_valid     = (pair_cnt == 0);
    s.overflow     = dropped_seen;
    return s;
  endfunction

  task automatic take_pair();
    logic [bdmd_pkg::DEPTH_BITS-1:0] a;
    logic [bdmd_pkg::DEPTH_BITS-1:0] b;
    logic [bdmd_pkg::DEPTH_BITS-1:0] d;
    a = near_depth_i[bdmd_pkg::DEPTH_BITS-1:0];
    b = far_depth_i[bdmd_pkg::DEPTH_BITS-1:0];
    if (!invalid_i) begin
      if (pair_cnt < bdmd_pkg::MAX_PAIRS) begin
        d = (a >= b) ? (a - b) : (b - a);
        diff_mem[pair_cnt] = d;
        diff_total += d;
        pair_cnt++;
      end else begin
        dropped_seen = 1'b1;
      end
    end
    if (last_i) begin
      expected_stats_q.insert(expected_stats_q.size(), predict_set_stats());
      diff_total   = 0;
      pair_cnt     = 0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic check_result();
    set_stats_t e;
    if (expected_stats_q.size() == 0) begin
      $error("result transfer with no set pending");
      fail_count_o++;
    end else begin
      e = expected_stats_q.pop_front();
      if (mean_depth_i !== e.mean_depth) begin
        $error("mean_depth: expected %0d, got %0d", e.mean_depth, mean_depth_i);
        fail_count_o++;
      end
      if (mean_abs_dev_i !== e.mean_abs_dev) begin
        $error("mean_abs_dev: expected %0d, got %0d", e.mean_abs_dev, mean_abs_dev_i);
        fail_count_o++;
      end
      if (valid_count_i !== e.valid_count) begin
        $error("valid_count: expected %0d, got %0d", e.valid_count, valid_count_i);
        fail_count_o++;
      end
      if (no_valid_i !== e.no_valid) begin
        $error("no_valid: expected %0d, got %0d", e.no_valid, no_valid_i);
        fail_count_o++;
      end
      if (overflow_i !== e.overflow) begin
        $error("overflow: expected %0d, got %0d", e.overflow, overflow_i);
        fail_count_o++;
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_total   = 0;
      pair_cnt     = 0;
      dropped_seen = 1'b0;
      expected_stats_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) take_pair();
    end
    pending_o = expected_stats_q.size();
  end

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench top: drives depth pair sets into the block and reports the verdict
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 100;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid;
  logic                           in_ready;
  logic [bdmd_pkg::IN_W-1:0]      near_depth;
  logic [bdmd_pkg::IN_W-1:0]      far_depth;
  logic                           invalid;
  logic                           last;
  logic                           out_valid;
  logic                           out_ready;
  logic [bdmd_pkg::RES_W-1:0]     mean_depth;
  logic [bdmd_pkg::RES_W-1:0]     mean_abs_dev;
  logic [bdmd_pkg::CNT_OUT_W-1:0] valid_count;
  logic                           no_valid;
  logic                           overflow;
  int                             fail_count;
  int                             pending_sets;
  int                             burst_left;
  int                             random_sent;
  int                             idle_cycles;

  boundary_depth_mean_deviation_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .near_depth_i   (near_depth),
    .far_depth_i    (far_depth),
    .invalid_i      (invalid),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .mean_depth_o   (mean_depth),
    .mean_abs_dev_o (mean_abs_dev),
    .valid_count_o  (valid_count),
    .no_valid_o     (no_valid),
    .overflow_o     (overflow)
  );

  depth_stats_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .near_depth_i   (near_depth),
    .far_depth_i    (far_depth),
    .invalid_i      (invalid),
    .last_i         (last),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .mean_depth_i   (mean_depth),
    .mean_abs_dev_i (mean_abs_dev),
    .valid_count_i  (valid_count),
    .no_valid_i     (no_valid),
    .overflow_i     (overflow),
    .fail_count_o   (fail_count),
    .pending_o      (pending_sets)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                           input logic bad, input logic fin);
    int gap;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(50, 200);
      end else begin
        gap        = $urandom_range(0, 8);
        burst_left = $urandom_range(1, 20);
      end
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    near_depth = a;
    far_depth  = b;
    invalid    = bad;
    last       = fin;
    in_valid   = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  function automatic logic [15:0] pick_depth(input int style, input logic [15:0] other);
    case (style)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 15));
      2: return other + 16'($urandom_range(0, 64)) - 16'd32;
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic send_random_set(input int n);
    int          style;
    int          bad_pct;
    logic [15:0] a;
    logic [15:0] b;
    style   = $urandom_range(0, 3);
    bad_pct = $urandom_range(0, 30);
    for (int i = 0; i < n; i++) begin
      a = pick_depth(style == 2 ? 0 : style, 16'h0);
      b = pick_depth(style, a);
      send_pair(a, b, $urandom_range(0, 99) < bad_pct, i == n - 1);
      random_sent++;
    end
  endtask

  // Receiver: ready pattern switches among always-ready, random, sparse and never-ready modes
  initial begin
    int mode;
    int span;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 7) == 0);
          default: out_ready = 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    near_depth  = '0;
    far_depth   = '0;
    invalid     = 1'b0;
    last        = 1'b0;
    burst_left  = 0;
    random_sent = 0;
    idle_cycles = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extreme depth values, in one- and two-pair sets
    send_pair(16'h0000, 16'hFFFF, 1'b0, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b0, 1'b1);
    // set of only an invalid last pair
    send_pair(16'h1234, 16'h4321, 1'b1, 1'b1);
    // all pairs invalid
    send_pair(16'hFFFF, 16'h0000, 1'b1, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b1, 1'b1);
    // valid pairs, invalid last
    send_pair(16'd10, 16'd3, 1'b0, 1'b0);
    send_pair(16'd4, 16'd20, 1'b0, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1, 1'b1);
    // truncation of mean and deviation
    send_pair(16'd1, 16'd0, 1'b0, 1'b0);
    send_pair(16'd0, 16'd2, 1'b0, 1'b0);
    send_pair(16'd7, 16'd7, 1'b0, 1'b1);
    send_pair(16'd0, 16'd1, 1'b0, 1'b0);
    send_pair(16'd0, 16'd1, 1'b0, 1'b0);
    send_pair(16'd65535, 16'd0, 1'b0, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      send_random_set(($urandom_range(0, 19) == 0) ? $urandom_range(41, 250)
                                                   : $urandom_range(1, 40));
    end
    in_valid = 1'b0;

    wait (pending_sets == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_sets == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
